/* sv/dudec_pkg.sv */
// Shared types, request codes and configuration constants for the debounced
// up/down event counter. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dudec_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ACTION_W = 3;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 64;
    localparam int DEB_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;

    localparam logic [ACTION_W-1:0] ACT_EDGE       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POLL       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_VALUE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_START      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_STOP       = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_OVF  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DOWN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd4;

    localparam logic [1:0]       RST_WIDTH_SELECT = 2'd3;
    localparam logic [DEB_W-1:0] RST_DEBOUNCE_US  = 16'd50;

    typedef enum logic [2:0] {
        OP_EDGE,
        OP_POLL,
        OP_LOAD_START,
        OP_LOAD_VALUE,
        OP_RUN,
        OP_HALT,
        OP_CLR_OVF,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  time_us;
        logic [COUNT_W-1:0] new_value;
    } item_t;

    typedef struct packed {
        logic               count_down;
        logic [COUNT_W-1:0] preset_value;
        logic [1:0]         width_select;
        logic [DEB_W-1:0]   debounce_us;
        logic               enabled;
    } cfg_t;

    function automatic logic [COUNT_W-1:0] width_limit(input logic [1:0] sel);
        logic [COUNT_W-1:0] lim;
        unique case (sel)
            2'd0:    lim = 64'h0000_0000_0000_00FF;
            2'd1:    lim = 64'h0000_0000_0000_FFFF;
            2'd2:    lim = 64'h0000_0000_FFFF_FFFF;
            default: lim = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return lim;
    endfunction

endpackage

/* sv/dudec_front.sv */
// Front end of the counter: accepts requests from the input stream and
// classifies the action code into an internal operation. Uses dudec_pkg.
`timescale 1ns / 1ps

module dudec_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dudec_pkg::ACTION_W-1:0]    in_action,
    input  logic [dudec_pkg::TIME_W-1:0]      in_time_us,
    input  logic [dudec_pkg::COUNT_W-1:0]     in_new_value,
    output logic                              push_valid,
    input  logic                              push_ready,
    output dudec_pkg::item_t                  push_item
);

    dudec_pkg::op_t op;

    always_comb begin
        unique case (in_action)
            dudec_pkg::ACT_EDGE:      op = dudec_pkg::OP_EDGE;
            dudec_pkg::ACT_POLL:      op = dudec_pkg::OP_POLL;
            dudec_pkg::ACT_RESET:     op = dudec_pkg::OP_LOAD_START;
            dudec_pkg::ACT_SET_VALUE: op = dudec_pkg::OP_LOAD_VALUE;
            dudec_pkg::ACT_START:     op = dudec_pkg::OP_RUN;
            dudec_pkg::ACT_STOP:      op = dudec_pkg::OP_HALT;
            dudec_pkg::ACT_CLEAR_OVF: op = dudec_pkg::OP_CLR_OVF;
            default:                  op = dudec_pkg::OP_NOP;
        endcase
    end

    assign s_axis_tready       = push_ready;
    assign push_valid          = s_axis_tvalid;
    assign push_item.op        = op;
    assign push_item.time_us   = in_time_us;
    assign push_item.new_value = in_new_value;

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(s_axis_tvalid && s_axis_tready) || (push_valid && push_ready))
                else $error("accepted request not passed to the queue");
        end
    end

endmodule

/* sv/dudec_queue.sv */
// Short request queue between the front end and the execution back end.
// Holds classified requests of type dudec_pkg::item_t.
`timescale 1ns / 1ps

module dudec_queue #(
    parameter int DEPTH = dudec_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  dudec_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dudec_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dudec_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/dudec_back.sv */
// Back end of the counter: executes one classified request per cycle on the
// counter state unless m_axis stalls, and holds the result in the output register. Uses dudec_pkg.
`timescale 1ns / 1ps

module dudec_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dudec_pkg::cfg_t                cfg,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  dudec_pkg::item_t               pop_item,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dudec_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic [dudec_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [dudec_pkg::TIME_W-1:0]  last_edge_reg, last_edge_next;
    logic                          running_reg, running_next;
    logic                          overflow_reg, overflow_next;
    logic                          m_valid_reg, m_valid_next;
    logic [dudec_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [dudec_pkg::TIME_W-1:0]  gap;
    logic                          take;

    assign pop_ready = !m_valid_reg || m_axis_tready;
    assign take      = pop_valid && pop_ready;
    assign gap       = pop_item.time_us - last_edge_reg;

    always_comb begin
        count_next     = count_reg;
        last_edge_next = last_edge_reg;
        running_next   = running_reg;
        overflow_next  = overflow_reg;
        if (take) begin
            unique case (pop_item.op)
                dudec_pkg::OP_EDGE: begin
                    if (running_reg && (gap > {16'd0, cfg.debounce_us})) begin
                        if (!cfg.count_down) begin
                            count_next = count_reg + 64'd1;
                        end else if (count_reg != '0) begin
                            count_next = count_reg - 64'd1;
                        end
                        last_edge_next = pop_item.time_us;
                    end
                end
                dudec_pkg::OP_POLL: begin
                    if (cfg.enabled && !cfg.count_down &&
                        (count_reg > dudec_pkg::width_limit(cfg.width_select))) begin
                        count_next    = cfg.preset_value;
                        overflow_next = 1'b1;
                    end
                end
                dudec_pkg::OP_LOAD_START: count_next    = cfg.preset_value;
                dudec_pkg::OP_LOAD_VALUE: count_next    = pop_item.new_value;
                dudec_pkg::OP_RUN:        running_next  = 1'b1;
                dudec_pkg::OP_HALT:       running_next  = 1'b0;
                dudec_pkg::OP_CLR_OVF:    overflow_next = 1'b0;
                dudec_pkg::OP_NOP:        ;
            endcase
        end
    end

    always_comb begin
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            last_edge_reg <= '0;
            running_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            last_edge_reg <= last_edge_next;
            running_reg   <= running_next;
            overflow_reg  <= overflow_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= {6'd0, running_next, overflow_next, count_next};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_take_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("executed request left no result");

    a_halt_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (pop_item.op == dudec_pkg::OP_HALT) |=> !running_reg)
        else $error("stop request left the counter running");

    a_overflow_from_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(overflow_reg) |-> $past(take && (pop_item.op == dudec_pkg::OP_POLL)))
        else $error("overflow flag set outside a poll");

    a_down_edge_no_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (pop_item.op == dudec_pkg::OP_EDGE) && cfg.count_down
        |=> count_reg <= $past(count_reg))
        else $error("down-mode edge raised the count");

endmodule

/* sv/debounced_up_down_event_counter.sv */
// Debounced up/down event counter, top level. A request accepted on s_axis is
// written into the queue, executed from there by the back end, and its result
// is held in the back end's output register for m_axis. Throughput: one request
// per cycle while m_axis_tready does not stall the back end's output register.
// Reset: synchronous, active-low aresetn clears the count, the edge time, the
// run and overflow flags and the queue, and loads the registers' defaults.
`timescale 1ns / 1ps

module debounced_up_down_event_counter #(
    parameter int QUEUE_DEPTH = dudec_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action [2:0], time_us [34:3], new_value [98:35], zero fill [103:99]
    input  logic [dudec_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // count_value [63:0], overflow_seen [64], is_running [65], zero fill [71:66]
    output logic [dudec_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [dudec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dudec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    dudec_pkg::cfg_t  cfg_reg;
    dudec_pkg::item_t push_item, pop_item;
    logic             push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count_down   <= 1'b0;
            cfg_reg.preset_value <= '0;
            cfg_reg.width_select <= dudec_pkg::RST_WIDTH_SELECT;
            cfg_reg.debounce_us  <= dudec_pkg::RST_DEBOUNCE_US;
            cfg_reg.enabled      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dudec_pkg::CFG_COUNT_DOWN:   cfg_reg.count_down   <= cfg_wdata[0];
                dudec_pkg::CFG_PRESET_VALUE: cfg_reg.preset_value <= cfg_wdata;
                dudec_pkg::CFG_WIDTH_SELECT: cfg_reg.width_select <= cfg_wdata[1:0];
                dudec_pkg::CFG_DEBOUNCE_US:  cfg_reg.debounce_us  <= cfg_wdata[15:0];
                dudec_pkg::CFG_ENABLED:      cfg_reg.enabled      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dudec_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_action     (s_axis_tdata[2:0]),
        .in_time_us    (s_axis_tdata[34:3]),
        .in_new_value  (s_axis_tdata[98:35]),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    dudec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dudec_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
